// File: rtl/core/hnt_pkg.sv
// Shared types, codes and constants of the hashed name table.
`timescale 1ns / 1ps

package hnt_pkg;

  localparam int unsigned TableSlotsDef = 256;
  localparam int unsigned KeyBytes      = 32;
  localparam int unsigned KeyWords      = 4;
  localparam int unsigned KeyWordW      = 64;
  localparam int unsigned RawKeyW       = 248;
  localparam int unsigned ValueW        = 16;
  localparam int unsigned SlotW         = 8;
  localparam int unsigned ModStepBits   = 4;
  localparam logic [31:0] HashSeed      = 32'd5381;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_UPDATED   = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_CLEARED   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_BYTE,
    HS_MOD,
    HS_DONE
  } hash_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } core_state_e;

  typedef struct packed {
    logic       rd_key;
    logic       rd_val;
    logic       wr_key;
    logic       wr_val;
    logic       set_valid;
    logic       clear_all;
    logic [1:0] word;
  } tbl_ctl_t;

endpackage

// File: rtl/core/hashed_name_table_linear_probe_core.sv
// Top level: request sequencer of the linear-probe name table.
`timescale 1ns / 1ps

// Name table that maps zero-terminated names of up to 31 bytes to 16-bit values.
// Request channel (in_valid_i/in_ready_o): kind, four name words, entry value.
// kind 0 inserts or updates, 1 (and 3) looks up, 2 clears the whole table.
// Response channel (out_valid_o/out_ready_i): status, slot, found_value.
// One request is in work at a time; in_ready_o is high only when idle.
// The hash takes the name one byte at a time, then reduces it to the home slot
// at 4 remainder bits per cycle; every occupied slot on the probe path has its
// key read one key word per cycle from the single-port key memory, and a new
// key is written word by word, with the value and valid flag set on the last.
// The response sits in an output register; a new request is taken while it
// waits, and the sequencer holds a finished result until that register frees.
// Reset empties every slot at once through the valid flags; key and value
// memories are not cleared and are only read in slots marked valid.
module hashed_name_table_linear_probe_core #(
  parameter int unsigned TableSlots = hnt_pkg::TableSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [63:0]                   key_bytes_0_7_i,
  input  logic [63:0]                   key_bytes_8_15_i,
  input  logic [63:0]                   key_bytes_16_23_i,
  input  logic [55:0]                   key_bytes_24_30_i,
  input  logic [15:0]                   entry_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [7:0]                    slot_o,
  output logic [15:0]                   found_value_o
);

  localparam int unsigned IdxW = (TableSlots > 1) ? $clog2(TableSlots) : 1;
  localparam int unsigned CntW = $clog2(TableSlots + 1);

  hnt_pkg::core_state_e state_q, state_d;
  hnt_pkg::tbl_ctl_t    ctl;

  logic                      hash_start;
  logic                      hash_done;
  logic [IdxW-1:0]           hash_home;
  logic [hnt_pkg::KeyWords-1:0][hnt_pkg::KeyWordW-1:0] hash_key;
  logic [hnt_pkg::KeyWordW-1:0] key_word;
  logic [hnt_pkg::KeyWordW-1:0] key_rdata;
  logic [hnt_pkg::ValueW-1:0]   val_rdata;
  logic                      slot_vld;

  logic [1:0]                kind_q, kind_d;
  logic [hnt_pkg::ValueW-1:0] val_q, val_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [CntW-1:0]           n_q, n_d;
  logic [1:0]                rword_q, rword_d;
  logic                      match_q, match_d;
  hnt_pkg::status_e          res_status_q, res_status_d;
  logic [IdxW-1:0]           res_slot_q, res_slot_d;
  logic [hnt_pkg::ValueW-1:0] res_value_q, res_value_d;
  logic                      out_valid_q, out_valid_d;
  hnt_pkg::status_e          out_status_q, out_status_d;
  logic [IdxW-1:0]           out_slot_q, out_slot_d;
  logic [hnt_pkg::ValueW-1:0] out_value_q, out_value_d;

  logic is_insert;
  logic cmp;
  logic probe_last;
  logic out_free;
  logic [IdxW-1:0] idx_next;

  assign in_ready_o = (state_q == hnt_pkg::ST_IDLE);
  assign is_insert  = (kind_q == hnt_pkg::KIND_INSERT);
  assign key_word   = hash_key[rword_q];
  assign cmp        = match_q && (key_rdata == key_word);
  assign probe_last = (n_q == CntW'(TableSlots - 1));
  assign out_free   = !out_valid_q || out_ready_i;
  assign idx_next   = (idx_q == IdxW'(TableSlots - 1)) ? '0 : idx_q + IdxW'(1);

  hnt_hash #(
    .TableSlots (TableSlots)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .raw_i   ({key_bytes_24_30_i, key_bytes_16_23_i, key_bytes_8_15_i, key_bytes_0_7_i}),
    .done_o  (hash_done),
    .home_o  (hash_home),
    .key_o   (hash_key)
  );

  hnt_table #(
    .TableSlots (TableSlots)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .slot_i       (idx_q),
    .key_wdata_i  (key_word),
    .val_wdata_i  (val_q),
    .key_rdata_o  (key_rdata),
    .val_rdata_o  (val_rdata),
    .slot_valid_o (slot_vld)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hnt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (kind_i == hnt_pkg::KIND_CLEAR) ? hnt_pkg::ST_DONE : hnt_pkg::ST_HASH;
        end
      end
      hnt_pkg::ST_HASH: if (hash_done) state_d = hnt_pkg::ST_PROBE;
      hnt_pkg::ST_PROBE: begin
        if (slot_vld) state_d = hnt_pkg::ST_READ;
        else if (is_insert) state_d = hnt_pkg::ST_WRITE;
        else state_d = hnt_pkg::ST_DONE;
      end
      hnt_pkg::ST_READ: begin
        if (rword_q == 2'd3) begin
          state_d = (cmp || probe_last) ? hnt_pkg::ST_DONE : hnt_pkg::ST_PROBE;
        end
      end
      hnt_pkg::ST_WRITE: if (rword_q == 2'd3) state_d = hnt_pkg::ST_DONE;
      hnt_pkg::ST_DONE:  if (out_free) state_d = hnt_pkg::ST_IDLE;
      default:           state_d = hnt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    hash_start   = 1'b0;
    kind_d       = kind_q;
    val_d        = val_q;
    idx_d        = idx_q;
    n_d          = n_q;
    rword_d      = rword_q;
    match_d      = match_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_value_d  = out_value_q;
    unique case (state_q)
      hnt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          kind_d = kind_i;
          val_d  = entry_value_i;
          if (kind_i == hnt_pkg::KIND_CLEAR) begin
            ctl.clear_all = 1'b1;
            res_status_d  = hnt_pkg::STAT_CLEARED;
            res_slot_d    = '0;
            res_value_d   = '0;
          end else begin
            hash_start = 1'b1;
          end
        end
      end
      hnt_pkg::ST_HASH: begin
        if (hash_done) begin
          idx_d = hash_home;
          n_d   = '0;
        end
      end
      hnt_pkg::ST_PROBE: begin
        rword_d = 2'd0;
        if (slot_vld) begin
          ctl.rd_key = 1'b1;
          ctl.rd_val = 1'b1;
          ctl.word   = 2'd0;
          match_d    = 1'b1;
        end else if (is_insert) begin
          res_status_d = hnt_pkg::STAT_INSERTED;
          res_slot_d   = idx_q;
          res_value_d  = val_q;
        end else begin
          res_status_d = hnt_pkg::STAT_NOT_FOUND;
          res_slot_d   = '0;
          res_value_d  = '0;
        end
      end
      hnt_pkg::ST_READ: begin
        if (rword_q != 2'd3) begin
          ctl.rd_key = 1'b1;
          ctl.word   = rword_q + 2'd1;
          rword_d    = rword_q + 2'd1;
          match_d    = cmp;
        end else if (cmp) begin
          res_slot_d = idx_q;
          if (is_insert) begin
            ctl.wr_val   = 1'b1;
            res_status_d = hnt_pkg::STAT_UPDATED;
            res_value_d  = val_q;
          end else begin
            res_status_d = hnt_pkg::STAT_FOUND;
            res_value_d  = val_rdata;
          end
        end else begin
          idx_d = idx_next;
          n_d   = n_q + CntW'(1);
          if (probe_last) begin
            res_status_d = is_insert ? hnt_pkg::STAT_FULL : hnt_pkg::STAT_NOT_FOUND;
            res_slot_d   = '0;
            res_value_d  = '0;
          end
        end
      end
      hnt_pkg::ST_WRITE: begin
        ctl.wr_key = 1'b1;
        ctl.word   = rword_q;
        rword_d    = rword_q + 2'd1;
        if (rword_q == 2'd3) begin
          ctl.wr_val    = 1'b1;
          ctl.set_valid = 1'b1;
        end
      end
      hnt_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_value_d  = res_value_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hnt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      rword_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      rword_q     <= rword_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    match_q      <= match_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_value_q  <= out_value_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_o        = hnt_pkg::SlotW'(out_slot_q);
  assign found_value_o = out_value_q;

`ifndef SYNTHESIS
  a_read_valid_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hnt_pkg::ST_READ |-> slot_vld)
    else $error("key read from a free slot");

  a_write_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hnt_pkg::ST_WRITE |-> !slot_vld)
    else $error("new key written over an occupied slot");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hnt_pkg::ST_PROBE |-> n_q < CntW'(TableSlots))
    else $error("probe ran past a full circle");

  a_hash_done_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> state_q == hnt_pkg::ST_HASH)
    else $error("hash result arrived outside the hash wait");
`endif

endmodule

// File: rtl/core/hnt_hash.sv
// Name cleaner, DJB2 hash (one byte per cycle) and home slot reduction.
`timescale 1ns / 1ps

module hnt_hash #(
  parameter int unsigned TableSlots = hnt_pkg::TableSlotsDef,
  localparam int unsigned IdxW = (TableSlots > 1) ? $clog2(TableSlots) : 1
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start_i,
  input  logic [hnt_pkg::RawKeyW-1:0]                  raw_i,
  output logic                                         done_o,
  output logic [IdxW-1:0]                              home_o,
  output logic [hnt_pkg::KeyWords-1:0][hnt_pkg::KeyWordW-1:0] key_o
);

  localparam int unsigned KeyW    = hnt_pkg::KeyWords * hnt_pkg::KeyWordW;
  localparam int unsigned ModCycW = $clog2(32 / hnt_pkg::ModStepBits);

  hnt_pkg::hash_state_e state_q, state_d;

  logic [hnt_pkg::RawKeyW-1:0] raw_q, raw_d;
  logic [KeyW-1:0]             key_q, key_d;
  logic [31:0]                 h_q, h_d;
  logic [4:0]                  bcnt_q, bcnt_d;
  logic [IdxW-1:0]             rem_q, rem_d;
  logic [ModCycW-1:0]          mcnt_q, mcnt_d;
  logic [7:0]                  cur_byte;
  logic                        byte_stop;

  assign cur_byte  = raw_q[7:0];
  assign byte_stop = (cur_byte == 8'd0) || (bcnt_q == 5'(hnt_pkg::KeyBytes - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hnt_pkg::HS_IDLE: if (start_i) state_d = hnt_pkg::HS_BYTE;
      hnt_pkg::HS_BYTE: if (byte_stop) state_d = hnt_pkg::HS_MOD;
      hnt_pkg::HS_MOD:  if (mcnt_q == '1) state_d = hnt_pkg::HS_DONE;
      hnt_pkg::HS_DONE: state_d = hnt_pkg::HS_IDLE;
      default:          state_d = hnt_pkg::HS_IDLE;
    endcase
  end

  always_comb begin
    logic [IdxW:0]   r;
    logic [IdxW-1:0] rr;
    raw_d  = raw_q;
    key_d  = key_q;
    h_d    = h_q;
    bcnt_d = bcnt_q;
    rem_d  = rem_q;
    mcnt_d = mcnt_q;
    r      = '0;
    rr     = rem_q;
    unique case (state_q)
      hnt_pkg::HS_IDLE: begin
        if (start_i) begin
          raw_d  = raw_i;
          key_d  = '0;
          h_d    = hnt_pkg::HashSeed;
          bcnt_d = '0;
        end
      end
      hnt_pkg::HS_BYTE: begin
        if (byte_stop) begin
          rem_d  = '0;
          mcnt_d = '0;
        end else begin
          key_d[{bcnt_q, 3'b000} +: 8] = cur_byte;
          h_d    = (h_q << 5) + h_q + {24'd0, cur_byte};
          raw_d  = raw_q >> 8;
          bcnt_d = bcnt_q + 5'd1;
        end
      end
      hnt_pkg::HS_MOD: begin
        for (int k = 0; k < int'(hnt_pkg::ModStepBits); k++) begin
          r = {rr, h_q[31 - k]};
          if (r >= (IdxW + 1)'(TableSlots)) r = r - (IdxW + 1)'(TableSlots);
          rr = r[IdxW-1:0];
        end
        rem_d  = rr;
        h_d    = h_q << hnt_pkg::ModStepBits;
        mcnt_d = mcnt_q + ModCycW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hnt_pkg::HS_IDLE;
      bcnt_q  <= '0;
      mcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      bcnt_q  <= bcnt_d;
      mcnt_q  <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q <= raw_d;
    key_q <= key_d;
    h_q   <= h_d;
    rem_q <= rem_d;
  end

  assign done_o = (state_q == hnt_pkg::HS_DONE);
  assign home_o = rem_q;
  assign key_o  = key_q;

endmodule

// File: rtl/core/hnt_table.sv
// Key and value memories with per-slot valid flags.
`timescale 1ns / 1ps

module hnt_table #(
  parameter int unsigned TableSlots = hnt_pkg::TableSlotsDef,
  localparam int unsigned IdxW = (TableSlots > 1) ? $clog2(TableSlots) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hnt_pkg::tbl_ctl_t             ctl_i,
  input  logic [IdxW-1:0]               slot_i,
  input  logic [hnt_pkg::KeyWordW-1:0]  key_wdata_i,
  input  logic [hnt_pkg::ValueW-1:0]    val_wdata_i,
  output logic [hnt_pkg::KeyWordW-1:0]  key_rdata_o,
  output logic [hnt_pkg::ValueW-1:0]    val_rdata_o,
  output logic                          slot_valid_o
);

  localparam int unsigned KeyDepth = TableSlots * hnt_pkg::KeyWords;

  logic [hnt_pkg::KeyWordW-1:0] key_mem [KeyDepth];
  logic [hnt_pkg::ValueW-1:0]   val_mem [TableSlots];
  logic [TableSlots-1:0]        valid_q;
  logic [IdxW+1:0]              key_addr;

  assign key_addr = {slot_i, ctl_i.word};

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_key) key_mem[key_addr] <= key_wdata_i;
    if (ctl_i.rd_key) key_rdata_o <= key_mem[key_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_val) val_mem[slot_i] <= val_wdata_i;
    if (ctl_i.rd_val) val_rdata_o <= val_mem[slot_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.clear_all) begin
      valid_q <= '0;
    end else if (ctl_i.set_valid) begin
      valid_q[slot_i] <= 1'b1;
    end
  end

  assign slot_valid_o = valid_q[slot_i];

endmodule

// File: bench/tb.sv
// Testbench of the linear-probe name table: random and directed requests against a predictor.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TableSlots  = hnt_pkg::TableSlotsDef;
  localparam int unsigned RawKeyW     = hnt_pkg::RawKeyW;
  localparam int unsigned NameBytes   = hnt_pkg::KeyBytes - 1;
  localparam logic [1:0]  KindSpare   = 2'd3;
  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned DrainCycles = 2000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned RandomItems = 1400;
  localparam int unsigned FillAt      = 800;
  localparam int unsigned PoolNames   = 48;
  localparam int unsigned ClusterBase = 32;

  typedef struct {
    logic [1:0]         kind;
    logic [RawKeyW-1:0] raw;
    logic [15:0]        value;
    bit                 drain;
  } name_req_t;

  typedef struct {
    hnt_pkg::status_e status;
    logic [7:0]       slot;
    logic [15:0]      value;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [1:0]  kind = hnt_pkg::KIND_INSERT;
  logic [63:0] key_0_7 = '0;
  logic [63:0] key_8_15 = '0;
  logic [63:0] key_16_23 = '0;
  logic [55:0] key_24_30 = '0;
  logic [15:0] entry_value = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [2:0]  status;
  logic [7:0]  slot;
  logic [15:0] found_value;

  name_req_t     req_fifo[$];
  table_result_t result_fifo[$];
  name_req_t     cur_req;

  logic [RawKeyW-1:0] tbl_name[TableSlots];
  logic [15:0]        tbl_value[TableSlots];
  bit                 tbl_used[TableSlots];
  logic [RawKeyW-1:0] name_pool[PoolNames];

  int unsigned n_acc = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold = 250;
  int unsigned cycles = 0;
  int unsigned err_cnt = 0;

  hashed_name_table_linear_probe_core u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (req_valid),
    .in_ready_o        (req_ready),
    .kind_i            (kind),
    .key_bytes_0_7_i   (key_0_7),
    .key_bytes_8_15_i  (key_8_15),
    .key_bytes_16_23_i (key_16_23),
    .key_bytes_24_30_i (key_24_30),
    .entry_value_i     (entry_value),
    .out_valid_o       (rsp_valid),
    .out_ready_i       (rsp_ready),
    .status_o          (status),
    .slot_o            (slot),
    .found_value_o     (found_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned home_slot(input logic [RawKeyW-1:0] raw,
                                            output logic [RawKeyW-1:0] clean);
    logic [31:0] h;
    logic [7:0]  b;
    bit          ended;
    int          i;
    h = hnt_pkg::HashSeed;
    clean = '0;
    ended = 1'b0;
    for (i = 0; i < NameBytes; i++) begin
      b = raw[8*i +: 8];
      if (b == 8'd0) ended = 1'b1;
      if (!ended) begin
        clean[8*i +: 8] = b;
        h = h * 32'd33 + {24'd0, b};
      end
    end
    return h % TableSlots;
  endfunction

  function automatic void predict_table_op(input name_req_t r);
    logic [RawKeyW-1:0] clean;
    int unsigned        idx;
    int unsigned        n;
    bit                 done;
    table_result_t      res;
    res.status = hnt_pkg::STAT_NOT_FOUND;
    res.slot = '0;
    res.value = '0;
    done = 1'b0;
    if (r.kind == hnt_pkg::KIND_CLEAR) begin
      for (n = 0; n < TableSlots; n++) tbl_used[n] = 1'b0;
      res.status = hnt_pkg::STAT_CLEARED;
    end else begin
      idx = home_slot(r.raw, clean);
      if (r.kind == hnt_pkg::KIND_INSERT) begin
        res.status = hnt_pkg::STAT_FULL;
        for (n = 0; n < TableSlots && !done; n++) begin
          if (!tbl_used[idx] || tbl_name[idx] == clean) begin
            res.status = tbl_used[idx] ? hnt_pkg::STAT_UPDATED : hnt_pkg::STAT_INSERTED;
            tbl_used[idx] = 1'b1;
            tbl_name[idx] = clean;
            tbl_value[idx] = r.value;
            res.slot = 8'(idx);
            res.value = r.value;
            done = 1'b1;
          end else begin
            idx = (idx + 1) % TableSlots;
          end
        end
      end else begin
        for (n = 0; n < TableSlots && !done; n++) begin
          if (!tbl_used[idx]) begin
            done = 1'b1;
          end else if (tbl_name[idx] == clean) begin
            res.status = hnt_pkg::STAT_FOUND;
            res.slot = 8'(idx);
            res.value = tbl_value[idx];
            done = 1'b1;
          end else begin
            idx = (idx + 1) % TableSlots;
          end
        end
      end
    end
    result_fifo.push_back(res);
  endfunction

  function automatic logic [RawKeyW-1:0] random_name(input int unsigned len, input bit junk);
    logic [RawKeyW-1:0] raw;
    int                 i;
    raw = '0;
    for (i = 0; i < NameBytes; i++) begin
      if (i < len) raw[8*i +: 8] = 8'($urandom_range(1, 255));
      else if (i > len && junk) raw[8*i +: 8] = 8'($urandom);
    end
    return raw;
  endfunction

  function automatic logic [RawKeyW-1:0] with_junk(input logic [RawKeyW-1:0] raw);
    logic [RawKeyW-1:0] res;
    bit                 ended;
    int                 i;
    res = raw;
    ended = 1'b0;
    for (i = 0; i < NameBytes; i++) begin
      if (ended) res[8*i +: 8] = 8'($urandom);
      else if (raw[8*i +: 8] == 8'd0) ended = 1'b1;
    end
    return res;
  endfunction

  function automatic int unsigned name_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 8);
    return $urandom_range(0, NameBytes);
  endfunction

  function automatic logic [RawKeyW-1:0] name_at_home(input int unsigned target);
    logic [RawKeyW-1:0] raw;
    logic [RawKeyW-1:0] clean;
    do raw = random_name($urandom_range(1, 5), 1'b0);
    while (home_slot(raw, clean) != target);
    return raw;
  endfunction

  function automatic logic [RawKeyW-1:0] fill_name(input int unsigned i);
    logic [RawKeyW-1:0] raw;
    raw = '0;
    raw[7:0] = 8'h46;
    raw[15:8] = 8'(1 + i % 255);
    raw[23:16] = 8'(1 + i / 255);
    return raw;
  endfunction

  function automatic logic [15:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic push_req(input logic [1:0] k, input logic [RawKeyW-1:0] raw,
                          input logic [15:0] v, input bit drain);
    name_req_t r;
    r.kind = k;
    r.raw = raw;
    r.value = v;
    r.drain = drain;
    req_fifo.push_back(r);
  endtask

  // request driver
  always @(posedge clk) begin
    bit          busy;
    bit          idle;
    int unsigned phase;
    if (rst_n) begin
      busy = req_valid;
      if (req_valid && req_ready) begin
        predict_table_op(cur_req);
        n_acc <= n_acc + 1;
        busy = 1'b0;
      end
      if (!busy) begin
        phase = (n_acc / 100) % 4;
        idle = 1'b0;
        if (hold_left == 0) begin
          if (phase == 1) idle = $urandom_range(0, 99) < 88;
          else if (phase == 3) idle = $urandom_range(0, 99) < 38;
        end
        if (req_fifo.size() == 0) idle = 1'b1;
        else if (req_fifo[0].drain && result_fifo.size() != 0) idle = 1'b1;
        if (!idle) begin
          cur_req = req_fifo.pop_front();
          kind <= cur_req.kind;
          key_0_7 <= cur_req.raw[63:0];
          key_8_15 <= cur_req.raw[127:64];
          key_16_23 <= cur_req.raw[191:128];
          key_24_30 <= cur_req.raw[247:192];
          entry_value <= cur_req.value;
        end
        req_valid <= !idle;
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    table_result_t want;
    int unsigned   phase;
    bit            take;
    if (rst_n) begin
      if (rsp_valid && rsp_ready) begin
        if (result_fifo.size() == 0) begin
          $error("unexpected response: status %0d slot %0d found_value %0h",
                 status, slot, found_value);
          err_cnt++;
        end else begin
          want = result_fifo.pop_front();
          if (status !== want.status) begin
            $error("status: expected %s, got %0d", want.status.name(), status);
            err_cnt++;
          end
          if (slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, slot);
            err_cnt++;
          end
          if (found_value !== want.value) begin
            $error("found_value: expected %0h, got %0h", want.value, found_value);
            err_cnt++;
          end
        end
      end
      phase = (n_acc / 100) % 4;
      take = 1'b1;
      if (hold_left != 0) take = 1'b0;
      else if (phase == 2) take = $urandom_range(0, 99) >= 88;
      else if (phase == 3) take = $urandom_range(0, 99) >= 38;
      rsp_ready <= take;
    end
  end

  // hold off the response side for a long stretch now and then
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (n_acc >= next_hold) begin
        hold_left <= HoldCycles;
        next_hold <= next_hold + 900;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [RawKeyW-1:0] name_a;
    logic [RawKeyW-1:0] long_name;
    logic [RawKeyW-1:0] raw;
    logic [1:0]         k;
    int unsigned        i;
    int unsigned        j;
    int unsigned        r;

    for (i = 0; i < ClusterBase; i++) name_pool[i] = random_name(name_len(), 1'b0);
    for (i = ClusterBase; i < PoolNames; i++) name_pool[i] = name_at_home(100 + i % 2);

    name_a = random_name(1, 1'b0);
    long_name = {NameBytes{8'hFF}};
    push_req(hnt_pkg::KIND_LOOKUP, '0, 16'hFFFF, 1'b1);
    push_req(hnt_pkg::KIND_INSERT, '0, 16'hFFFF, 1'b0);
    push_req(hnt_pkg::KIND_LOOKUP, with_junk('0), 16'h0000, 1'b0);
    push_req(hnt_pkg::KIND_INSERT, long_name, 16'h0000, 1'b0);
    push_req(KindSpare, long_name, 16'hFFFF, 1'b0);
    push_req(hnt_pkg::KIND_INSERT, long_name, 16'hA5A5, 1'b0);
    push_req(hnt_pkg::KIND_LOOKUP, long_name, 16'h0000, 1'b0);
    push_req(hnt_pkg::KIND_INSERT, with_junk(name_a), 16'h1234, 1'b0);
    push_req(hnt_pkg::KIND_LOOKUP, name_a, 16'h0000, 1'b0);
    push_req(hnt_pkg::KIND_INSERT, name_a, 16'h4321, 1'b0);
    push_req(KindSpare, random_name(6, 1'b1), 16'h0000, 1'b0);
    for (i = 0; i < 4; i++)
      push_req(hnt_pkg::KIND_INSERT, name_pool[ClusterBase + 2 * i], 16'(i), 1'b0);
    push_req(hnt_pkg::KIND_LOOKUP, with_junk(name_pool[ClusterBase + 6]), 16'h0000, 1'b0);
    push_req(hnt_pkg::KIND_LOOKUP, name_pool[ClusterBase + 8], 16'h0000, 1'b0);
    push_req(hnt_pkg::KIND_CLEAR, {NameBytes{8'hFF}}, 16'hFFFF, 1'b0);
    push_req(hnt_pkg::KIND_LOOKUP, name_a, 16'h0000, 1'b0);
    push_req(hnt_pkg::KIND_LOOKUP, long_name, 16'h0000, 1'b0);
    push_req(hnt_pkg::KIND_INSERT, name_pool[ClusterBase + 6], 16'h8001, 1'b0);
    push_req(hnt_pkg::KIND_CLEAR, '0, 16'h0000, 1'b0);

    for (i = 0; i < RandomItems; i++) begin
      if (i == FillAt) begin
        push_req(hnt_pkg::KIND_CLEAR, random_name(name_len(), 1'b1), pick_value(), 1'b1);
        for (j = 0; j < TableSlots; j++)
          push_req(hnt_pkg::KIND_INSERT, fill_name(j), pick_value(), 1'b0);
        for (j = 0; j < 4; j++)
          push_req(hnt_pkg::KIND_INSERT, with_junk(fill_name(j * 60)), pick_value(), 1'b0);
        for (j = 0; j < 6; j++) begin
          push_req(hnt_pkg::KIND_INSERT, fill_name(TableSlots + j), pick_value(), 1'b0);
          push_req(hnt_pkg::KIND_LOOKUP, fill_name(j * 40 + 3), pick_value(), 1'b0);
          push_req(KindSpare, fill_name(TableSlots + 20 + j), pick_value(), 1'b0);
        end
        push_req(hnt_pkg::KIND_CLEAR, '0, pick_value(), 1'b0);
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        push_req(hnt_pkg::KIND_CLEAR, random_name(name_len(), 1'b1), pick_value(), i == 0);
      end else if (r < 85) begin
        raw = name_pool[$urandom_range(0, PoolNames - 1)];
        if ($urandom_range(0, 1) == 1) raw = with_junk(raw);
        if (r < 45) k = hnt_pkg::KIND_INSERT;
        else if ($urandom_range(0, 9) == 0) k = KindSpare;
        else k = hnt_pkg::KIND_LOOKUP;
        push_req(k, raw, pick_value(), i == 0);
      end else begin
        r = $urandom_range(0, 2);
        k = (r == 0) ? hnt_pkg::KIND_INSERT : (r == 1) ? hnt_pkg::KIND_LOOKUP : KindSpare;
        push_req(k, random_name(name_len(), $urandom_range(0, 1) == 1), pick_value(), i == 0);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    while (req_fifo.size() != 0 || req_valid || result_fifo.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (err_cnt == 0 && result_fifo.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/hnt_pkg.sv
rtl/core/hnt_hash.sv
rtl/core/hnt_table.sv
rtl/core/hashed_name_table_linear_probe_core.sv
bench/tb.sv
